FILE: hdl/lcdnw_pkg.sv
package lcdnw_pkg;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_POWERUP   = 5'd1,
    PH_HI_PULSE  = 5'd2,
    PH_HI_GAP    = 5'd3,
    PH_LO_PULSE  = 5'd4,
    PH_LO_GAP    = 5'd5,
    PH_ONE_PULSE = 5'd6,
    PH_ONE_GAP   = 5'd7,
    PH_EXTRA     = 5'd8
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SEND = 2'd1,
    KIND_INIT = 2'd2
  } kind_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] CFG_POWERUP_WAIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_WAIT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_HIGH   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_GAP    = 2'd3;

  localparam logic [14:0] INIT_WAIT_FIRST  = 15'd5000;
  localparam logic [14:0] INIT_WAIT_SECOND = 15'd200;
  localparam logic [3:0]  INIT_LAST_STEP   = 4'd9;
  localparam logic [3:0]  INIT_FIRST_CMD   = 4'd5;
  localparam logic [3:0]  NIB_SYNC         = 4'h3;
  localparam logic [3:0]  NIB_FOUR_BIT     = 4'h2;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
  } pins_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] held_byte;
    logic       held_select;
    logic [3:0] init_step;
    pins_t      pins;
  } seq_state_t;

  typedef struct packed {
    logic [14:0] powerup_wait;
    logic [14:0] long_wait;
    logic [7:0]  pulse_high;
    logic [7:0]  pulse_gap;
  } cfg_t;

  // function set, 4-bit two lines, display off, clear, display on, home address
  function automatic logic [7:0] init_cmd(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h28;
      4'd1:    c = 8'h08;
      4'd2:    c = 8'h01;
      4'd3:    c = 8'h0C;
      4'd4:    c = 8'h80;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/lcdnw_if.sv
interface lcdnw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       is_data;

  modport source (output valid, output kind, output data_byte, output is_data, input ready);
  modport sink   (input valid, input kind, input data_byte, input is_data, output ready);
endinterface

interface lcdnw_out_if;
  logic       valid;
  logic       ready;
  logic       rs_level;
  logic       enable_level;
  logic [3:0] data_nibble;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, output rs_level, output enable_level, output data_nibble,
                  output busy_res, output rejected, input ready);
  modport sink   (input valid, input rs_level, input enable_level, input data_nibble,
                  input busy_res, input rejected, output ready);
endinterface

interface lcdnw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcdnw_pkg::CfgIdxW-1:0]  index;
  logic [lcdnw_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/lcdnw_next.sv
module lcdnw_next #(
  parameter int unsigned WAIT_WIDTH = 15
) (
  input  lcdnw_pkg::cfg_t       cfg_i,
  input  lcdnw_pkg::seq_state_t state_i,
  input  logic [WAIT_WIDTH-1:0] wait_i,
  input  logic [1:0]            kind_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  is_data_i,
  output lcdnw_pkg::seq_state_t state_o,
  output logic [WAIT_WIDTH-1:0] wait_o,
  output logic                  rejected_o
);

  typedef struct packed {
    lcdnw_pkg::seq_state_t st;
    logic [WAIT_WIDTH-1:0] cnt;
  } full_t;

  localparam logic [24:0] WaitMax = 25'((64'd1 << WAIT_WIDTH) - 64'd1);

  function automatic logic [WAIT_WIDTH-1:0] sat_ld(logic [14:0] v);
    logic [24:0] w;
    w = 25'(v);
    return (w > WaitMax) ? WaitMax[WAIT_WIDTH-1:0] : w[WAIT_WIDTH-1:0];
  endfunction

  function automatic full_t begin_pulse(full_t f, lcdnw_pkg::phase_e ph, logic [3:0] nib,
                                        logic [WAIT_WIDTH-1:0] hi);
    full_t r;
    r             = f;
    r.st.pins.en  = 1'b1;
    r.st.pins.nib = nib;
    r.st.phase    = ph;
    r.cnt         = hi;
    return r;
  endfunction

  function automatic full_t start_stage(full_t f, logic [3:0] s, logic [WAIT_WIDTH-1:0] hi);
    full_t r;
    r              = f;
    r.st.init_step = s;
    r.st.pins.rs   = 1'b0;
    if (s <= 4'd3) begin
      r = begin_pulse(r, lcdnw_pkg::PH_ONE_PULSE, lcdnw_pkg::NIB_SYNC, hi);
    end else if (s == 4'd4) begin
      r = begin_pulse(r, lcdnw_pkg::PH_ONE_PULSE, lcdnw_pkg::NIB_FOUR_BIT, hi);
    end else begin
      r.st.held_byte   = lcdnw_pkg::init_cmd(s - lcdnw_pkg::INIT_FIRST_CMD);
      r.st.held_select = 1'b0;
      r = begin_pulse(r, lcdnw_pkg::PH_HI_PULSE, r.st.held_byte[7:4], hi);
    end
    return r;
  endfunction

  function automatic full_t step_over(full_t f, logic [WAIT_WIDTH-1:0] hi,
                                      logic [WAIT_WIDTH-1:0] gap,
                                      logic [WAIT_WIDTH-1:0] lng,
                                      logic [WAIT_WIDTH-1:0] first,
                                      logic [WAIT_WIDTH-1:0] second);
    full_t r;
    r = f;
    case (f.st.phase)
      lcdnw_pkg::PH_POWERUP: r = start_stage(r, 4'd1, hi);
      lcdnw_pkg::PH_HI_PULSE: begin
        r.st.pins.en = 1'b0;
        r.st.phase   = lcdnw_pkg::PH_HI_GAP;
        r.cnt        = gap;
      end
      lcdnw_pkg::PH_HI_GAP:
        r = begin_pulse(r, lcdnw_pkg::PH_LO_PULSE, f.st.held_byte[3:0], hi);
      lcdnw_pkg::PH_LO_PULSE: begin
        r.st.pins.en = 1'b0;
        r.st.phase   = lcdnw_pkg::PH_LO_GAP;
        r.cnt        = gap;
      end
      lcdnw_pkg::PH_ONE_PULSE: begin
        r.st.pins.en = 1'b0;
        r.st.phase   = lcdnw_pkg::PH_ONE_GAP;
        r.cnt        = gap;
      end
      lcdnw_pkg::PH_LO_GAP: begin
        // clear and home commands need the long settle time
        r.st.phase = lcdnw_pkg::PH_EXTRA;
        r.cnt      = (!f.st.held_select && f.st.held_byte[7:2] == 6'd0) ? lng : '0;
      end
      lcdnw_pkg::PH_ONE_GAP: begin
        r.st.phase = lcdnw_pkg::PH_EXTRA;
        r.cnt      = (f.st.init_step == 4'd1) ? first :
                     (f.st.init_step == 4'd2) ? second : '0;
      end
      lcdnw_pkg::PH_EXTRA: begin
        if (f.st.init_step != 4'd0 && f.st.init_step < lcdnw_pkg::INIT_LAST_STEP) begin
          r = start_stage(r, f.st.init_step + 4'd1, hi);
        end else begin
          r.st.init_step = 4'd0;
          r.st.phase     = lcdnw_pkg::PH_IDLE;
          r.cnt          = '0;
        end
      end
      default: begin
        r.st.phase     = lcdnw_pkg::PH_IDLE;
        r.cnt          = '0;
        r.st.init_step = 4'd0;
      end
    endcase
    return r;
  endfunction

  logic [WAIT_WIDTH-1:0] hi_ld, gap_ld, long_ld, pwr_ld, first_ld, second_ld;
  logic                  busy;
  logic                  settle;
  full_t                 f;

  assign hi_ld     = sat_ld((cfg_i.pulse_high == 8'd0) ? 15'd1 : 15'(cfg_i.pulse_high));
  assign gap_ld    = sat_ld(15'(cfg_i.pulse_gap));
  assign long_ld   = sat_ld(cfg_i.long_wait);
  assign pwr_ld    = sat_ld(cfg_i.powerup_wait);
  assign first_ld  = sat_ld(lcdnw_pkg::INIT_WAIT_FIRST);
  assign second_ld = sat_ld(lcdnw_pkg::INIT_WAIT_SECOND);
  assign busy      = (state_i.phase != lcdnw_pkg::PH_IDLE);

  always_comb begin
    f.st       = state_i;
    f.cnt      = wait_i;
    rejected_o = 1'b0;
    settle     = 1'b0;
    case (kind_i)
      lcdnw_pkg::KIND_TICK: begin
        if (busy) begin
          if (f.cnt != '0) f.cnt = f.cnt - 1'b1;
          settle = 1'b1;
        end
      end
      lcdnw_pkg::KIND_SEND: begin
        if (busy) begin
          rejected_o = 1'b1;
        end else begin
          f.st.held_byte   = data_byte_i;
          f.st.held_select = is_data_i;
          f.st.init_step   = 4'd0;
          f.st.pins.rs     = is_data_i;
          f = begin_pulse(f, lcdnw_pkg::PH_HI_PULSE, data_byte_i[7:4], hi_ld);
        end
      end
      lcdnw_pkg::KIND_INIT: begin
        if (busy) begin
          rejected_o = 1'b1;
        end else begin
          f.st.init_step = 4'd0;
          f.st.pins.rs   = 1'b0;
          f.st.pins.en   = 1'b0;
          f.st.phase     = lcdnw_pkg::PH_POWERUP;
          f.cnt          = pwr_ld;
          settle         = 1'b1;
        end
      end
      default: ;
    endcase
    // zero-length waits fall through; every pulse loads a nonzero count, so
    // at most three steps chain before the next stop
    for (int i = 0; i < 3; i++) begin
      if (settle && f.st.phase != lcdnw_pkg::PH_IDLE && f.cnt == '0) begin
        f = step_over(f, hi_ld, gap_ld, long_ld, first_ld, second_ld);
      end
    end
    state_o = f.st;
    wait_o  = f.cnt;
  end

endmodule

FILE: hdl/char_lcd_nibble_write_sequencer_core.sv
// Four-bit character LCD write sequencer. Every input item (one-microsecond
// tick, byte send, or init request) is taken on its handshake, and its result
// (pin levels, busy, rejected) appears in the output register on the next
// cycle; input ready stays high whenever that register is empty or being read,
// so one item per cycle is sustained while the result side keeps reading. All
// delays are counted in tick items, not clock cycles. Configuration writes are
// always ready and take effect for the next item.
module char_lcd_nibble_write_sequencer_core #(
  parameter int unsigned WAIT_WIDTH = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcdnw_in_if.sink    in_i,
  lcdnw_out_if.source out_o,
  lcdnw_cfg_if.sink   cfg_i
);

  lcdnw_pkg::cfg_t       cfg_q;
  lcdnw_pkg::seq_state_t state_q, state_d;
  logic [WAIT_WIDTH-1:0] wait_q, wait_d;
  logic                  rejected_d;
  logic                  out_valid_q;
  logic                  rejected_q;
  logic                  in_xfer;
  logic                  out_xfer;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_xfer    = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.powerup_wait <= 15'd20000;
      cfg_q.long_wait    <= 15'd2000;
      cfg_q.pulse_high   <= 8'd1;
      cfg_q.pulse_gap    <= 8'd45;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lcdnw_pkg::CFG_POWERUP_WAIT: cfg_q.powerup_wait <= cfg_i.data;
        lcdnw_pkg::CFG_LONG_WAIT:    cfg_q.long_wait    <= cfg_i.data;
        lcdnw_pkg::CFG_PULSE_HIGH:   cfg_q.pulse_high   <= cfg_i.data[7:0];
        lcdnw_pkg::CFG_PULSE_GAP:    cfg_q.pulse_gap    <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  lcdnw_next #(
    .WAIT_WIDTH(WAIT_WIDTH)
  ) u_next (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .wait_i     (wait_q),
    .kind_i     (in_i.kind),
    .data_byte_i(in_i.data_byte),
    .is_data_i  (in_i.is_data),
    .state_o    (state_d),
    .wait_o     (wait_d),
    .rejected_o (rejected_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: lcdnw_pkg::PH_IDLE, default: '0};
      wait_q      <= '0;
      out_valid_q <= 1'b0;
      rejected_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q     <= state_d;
        wait_q      <= wait_d;
        rejected_q  <= rejected_d;
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pins and busy in the result are the state as left by the last item
  assign out_o.valid        = out_valid_q;
  assign out_o.rs_level     = state_q.pins.rs;
  assign out_o.enable_level = state_q.pins.en;
  assign out_o.data_nibble  = state_q.pins.nib;
  assign out_o.busy_res     = (state_q.phase != lcdnw_pkg::PH_IDLE);
  assign out_o.rejected     = rejected_q;

`ifndef ASSERT_OFF
  a_busy_has_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase != lcdnw_pkg::PH_IDLE |-> wait_q != '0)
    else $error("sequence active with zero wait count");

  a_pulse_en_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == lcdnw_pkg::PH_HI_PULSE || state_q.phase == lcdnw_pkg::PH_LO_PULSE ||
     state_q.phase == lcdnw_pkg::PH_ONE_PULSE) |-> state_q.pins.en)
    else $error("enable low during pulse phase");

  a_idle_step_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == lcdnw_pkg::PH_IDLE |-> state_q.init_step == 4'd0)
    else $error("init step left over in idle");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rejected_q |-> out_o.busy_res)
    else $error("rejected result while not busy");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(state_q) && $stable(wait_q))
    else $error("state moved while result stalled");
`endif

endmodule

FILE: test/tb_char_lcd_nibble_write_sequencer_core.sv
module tb_char_lcd_nibble_write_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned RandomItems = 800;

  typedef struct packed {
    logic       rs_level;
    logic       enable_level;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       rejected;
  } pin_result_t;

  // Tracks the sequencer state and holds the pin levels each accepted item should produce.
  class lcd_pin_scoreboard;
    lcdnw_pkg::phase_e phase;
    logic [14:0]       wait_cnt;
    logic [7:0]        byte_q;
    logic              sel_q;
    logic [3:0]        step;
    lcdnw_pkg::pins_t  pins;
    lcdnw_pkg::cfg_t   cfg;
    logic [7:0]        boot_cmds [5];
    pin_result_t       expected_pins [$];
    int unsigned       mismatches;

    function new();
      boot_cmds = '{8'h28, 8'h08, 8'h01, 8'h0C, 8'h80};
      cfg = '{powerup_wait: 15'd20000, long_wait: 15'd2000, pulse_high: 8'd1, pulse_gap: 8'd45};
      phase = lcdnw_pkg::PH_IDLE;
      wait_cnt = '0;
      byte_q = '0;
      sel_q = 1'b0;
      step = '0;
      pins = '0;
      mismatches = 0;
    endfunction

    function bit busy();
      return phase != lcdnw_pkg::PH_IDLE;
    endfunction

    function int unsigned waiting_results();
      return expected_pins.size();
    endfunction

    function void set_cfg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        lcdnw_pkg::CFG_POWERUP_WAIT: cfg.powerup_wait = val;
        lcdnw_pkg::CFG_LONG_WAIT:    cfg.long_wait = val;
        lcdnw_pkg::CFG_PULSE_HIGH:   cfg.pulse_high = val[7:0];
        lcdnw_pkg::CFG_PULSE_GAP:    cfg.pulse_gap = val[7:0];
        default: ;
      endcase
    endfunction

    function void start_pulse(lcdnw_pkg::phase_e p, logic [3:0] nib);
      pins.en = 1'b1;
      pins.nib = nib;
      phase = p;
      // a zero high time still gives a visible strobe
      wait_cnt = (cfg.pulse_high == 8'd0) ? 15'd1 : 15'(cfg.pulse_high);
    endfunction

    function void start_wait(lcdnw_pkg::phase_e p, logic [14:0] d);
      phase = p;
      wait_cnt = d;
    endfunction

    function void start_stage(logic [3:0] s);
      step = s;
      pins.rs = 1'b0;
      if (s <= 4'd3) begin
        start_pulse(lcdnw_pkg::PH_ONE_PULSE, lcdnw_pkg::NIB_SYNC);
      end else if (s == 4'd4) begin
        start_pulse(lcdnw_pkg::PH_ONE_PULSE, lcdnw_pkg::NIB_FOUR_BIT);
      end else begin
        byte_q = boot_cmds[s - lcdnw_pkg::INIT_FIRST_CMD];
        sel_q = 1'b0;
        start_pulse(lcdnw_pkg::PH_HI_PULSE, byte_q[7:4]);
      end
    endfunction

    function void advance_phase();
      case (phase)
        lcdnw_pkg::PH_POWERUP:   start_stage(4'd1);
        lcdnw_pkg::PH_HI_PULSE: begin
          pins.en = 1'b0;
          start_wait(lcdnw_pkg::PH_HI_GAP, 15'(cfg.pulse_gap));
        end
        lcdnw_pkg::PH_HI_GAP:    start_pulse(lcdnw_pkg::PH_LO_PULSE, byte_q[3:0]);
        lcdnw_pkg::PH_LO_PULSE, lcdnw_pkg::PH_ONE_PULSE: begin
          pins.en = 1'b0;
          start_wait(phase == lcdnw_pkg::PH_LO_PULSE ? lcdnw_pkg::PH_LO_GAP
                                                     : lcdnw_pkg::PH_ONE_GAP,
                     15'(cfg.pulse_gap));
        end
        lcdnw_pkg::PH_LO_GAP: begin
          // clear and home need the long settle time
          start_wait(lcdnw_pkg::PH_EXTRA, (!sel_q && byte_q < 8'd4) ? cfg.long_wait : 15'd0);
        end
        lcdnw_pkg::PH_ONE_GAP: begin
          start_wait(lcdnw_pkg::PH_EXTRA, step == 4'd1 ? lcdnw_pkg::INIT_WAIT_FIRST
                             : (step == 4'd2 ? lcdnw_pkg::INIT_WAIT_SECOND : 15'd0));
        end
        lcdnw_pkg::PH_EXTRA: begin
          if (step >= 4'd1 && step < lcdnw_pkg::INIT_LAST_STEP) begin
            start_stage(step + 4'd1);
          end else begin
            step = '0;
            phase = lcdnw_pkg::PH_IDLE;
            wait_cnt = '0;
          end
        end
        default: begin
          phase = lcdnw_pkg::PH_IDLE;
          wait_cnt = '0;
          step = '0;
        end
      endcase
    endfunction

    // zero-length waits run through in the same item
    function void settle();
      while (phase != lcdnw_pkg::PH_IDLE && wait_cnt == 15'd0) advance_phase();
    endfunction

    function void note_item(logic [1:0] kind, logic [7:0] b, logic sel);
      pin_result_t r;
      bit was_busy;
      was_busy = busy();
      r = '0;
      case (kind)
        lcdnw_pkg::KIND_TICK: begin
          if (was_busy) begin
            if (wait_cnt != 15'd0) wait_cnt--;
            settle();
          end
        end
        lcdnw_pkg::KIND_SEND, lcdnw_pkg::KIND_INIT: begin
          if (was_busy) begin
            r.rejected = 1'b1;
          end else if (kind == lcdnw_pkg::KIND_SEND) begin
            byte_q = b;
            sel_q = sel;
            step = '0;
            pins.rs = sel;
            start_pulse(lcdnw_pkg::PH_HI_PULSE, b[7:4]);
          end else begin
            step = '0;
            pins.rs = 1'b0;
            pins.en = 1'b0;
            start_wait(lcdnw_pkg::PH_POWERUP, cfg.powerup_wait);
            settle();
          end
        end
        default: ;
      endcase
      r.rs_level = pins.rs;
      r.enable_level = pins.en;
      r.data_nibble = pins.nib;
      r.busy_res = busy();
      expected_pins.push_back(r);
    endfunction

    function void check_pins(pin_result_t got);
      pin_result_t want;
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: rs=%b en=%b nib=%h busy=%b rej=%b",
                   got.rs_level, got.enable_level, got.data_nibble, got.busy_res,
                   got.rejected);
        return;
      end
      want = expected_pins.pop_front();
      if (got.rs_level !== want.rs_level || got.enable_level !== want.enable_level ||
          got.data_nibble !== want.data_nibble || got.busy_res !== want.busy_res ||
          got.rejected !== want.rejected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pin mismatch at %0t: expected rs=%b en=%b nib=%h busy=%b rej=%b, got rs=%b en=%b nib=%h busy=%b rej=%b",
                   $realtime, want.rs_level, want.enable_level, want.data_nibble,
                   want.busy_res, want.rejected, got.rs_level, got.enable_level,
                   got.data_nibble, got.busy_res, got.rejected);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lcdnw_in_if  in_if();
  lcdnw_out_if out_if();
  lcdnw_cfg_if cfg_if();

  char_lcd_nibble_write_sequencer_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  lcd_pin_scoreboard sb = new();
  bit          idle_en = 1'b1;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall bursts while idling is enabled
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_pins('{out_if.rs_level, out_if.enable_level, out_if.data_nibble,
                      out_if.busy_res, out_if.rejected});
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic push_item(logic [1:0] kind, logic [7:0] b, logic sel);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.data_byte <= b;
    in_if.is_data <= sel;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(kind, b, sel);
    items_sent++;
  endtask

  // tick until idle; noise items land mid-sequence, sends and inits get rejected
  task automatic tick_to_idle(bit noisy);
    while (sb.busy()) begin
      if (noisy && $urandom_range(0, 11) == 0)
        push_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      else
        push_item(lcdnw_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.waiting_results() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [14:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_cfg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic cfg_all(logic [14:0] pw, logic [14:0] lw, logic [7:0] ph, logic [7:0] pg);
    cfg_write(lcdnw_pkg::CFG_POWERUP_WAIT, pw);
    cfg_write(lcdnw_pkg::CFG_LONG_WAIT, lw);
    cfg_write(lcdnw_pkg::CFG_PULSE_HIGH, 15'(ph));
    cfg_write(lcdnw_pkg::CFG_PULSE_GAP, 15'(pg));
  endtask

  initial begin : stimulus
    int unsigned rnd_start;
    int unsigned last_cfg;
    int unsigned n;
    in_if.valid = 1'b0;
    in_if.kind = lcdnw_pkg::KIND_TICK;
    in_if.data_byte = '0;
    in_if.is_data = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lcdnw_pkg::CFG_POWERUP_WAIT;
    cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: data byte, requests while busy, unused kind
    push_item(lcdnw_pkg::KIND_SEND, 8'hFF, 1'b1);
    push_item(lcdnw_pkg::KIND_SEND, 8'h00, 1'b0);
    push_item(lcdnw_pkg::KIND_INIT, 8'h00, 1'b0);
    push_item(KindUnused, 8'hFF, 1'b1);
    tick_to_idle(1'b0);
    push_item(KindUnused, 8'h00, 1'b0);
    push_item(lcdnw_pkg::KIND_TICK, 8'hFF, 1'b1);
    drain_results();

    // all waits zero, pulse high time zero
    cfg_all(15'd0, 15'd0, 8'd0, 8'd0);
    push_item(lcdnw_pkg::KIND_INIT, 8'h5A, 1'b1);
    tick_to_idle(1'b0);
    push_item(lcdnw_pkg::KIND_SEND, 8'h03, 1'b0);
    tick_to_idle(1'b0);
    push_item(lcdnw_pkg::KIND_SEND, 8'hA5, 1'b1);
    push_item(lcdnw_pkg::KIND_INIT, 8'hFF, 1'b0);
    tick_to_idle(1'b0);
    push_item(KindUnused, 8'h5A, 1'b0);
    drain_results();

    // all at maximum, then short settings for the rest of the sequence
    cfg_all(15'h7FFF, 15'h7FFF, 8'hFF, 8'hFF);
    push_item(lcdnw_pkg::KIND_SEND, 8'h01, 1'b0);
    push_item(lcdnw_pkg::KIND_INIT, 8'h00, 1'b0);
    push_item(lcdnw_pkg::KIND_SEND, 8'h80, 1'b1);
    repeat (4) push_item(lcdnw_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
    drain_results();
    cfg_all(15'd0, 15'd0, 8'd1, 8'd0);
    tick_to_idle(1'b0);
    drain_results();

    cfg_all(15'd12, 15'd9, 8'd2, 8'd3);
    rnd_start = items_sent;
    last_cfg = items_sent;
    while (items_sent - rnd_start < RandomItems) begin
      if (items_sent - rnd_start >= RandomItems * 3 / 4) idle_en = 1'b0;
      if (items_sent - last_cfg > 150) begin
        drain_results();
        cfg_all(15'($urandom_range(0, 40)), 15'($urandom_range(0, 30)),
                8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
        last_cfg = items_sent;
      end
      if ($urandom_range(0, 3) == 0) begin
        // clear, home and other low command codes
        push_item(lcdnw_pkg::KIND_SEND, 8'($urandom_range(0, 7)), 1'($urandom));
      end else begin
        push_item(lcdnw_pkg::KIND_SEND, 8'($urandom), 1'($urandom));
      end
      tick_to_idle(1'b1);
      n = $urandom_range(0, 3);
      repeat (n) push_item(lcdnw_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 9) == 0) push_item(KindUnused, 8'($urandom), 1'($urandom));
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.waiting_results() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
